// ----- sv/i6dd_pkg.sv -----
// Shared types, codes and letter tables for the ISO 6937 diacritic decoder.
// No dependencies; every other file in the project imports this package.
`default_nettype none

package i6dd_pkg;

  // Pending non-spacing mark, held between a mark byte and its base letter.
  typedef enum logic [2:0] {
    MARK_NONE   = 3'd0,
    MARK_ACUTE  = 3'd1,
    MARK_CARON  = 3'd2,
    MARK_RING   = 3'd3,
    MARK_UMLAUT = 3'd4
  } mark_e;

  // Configuration register indexes (word addresses on the APB port).
  typedef enum logic [1:0] {
    REG_ACUTE  = 2'd0,
    REG_CARON  = 2'd1,
    REG_RING   = 2'd2,
    REG_UMLAUT = 2'd3
  } reg_idx_e;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 9;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  localparam logic [ByteW-1:0] AcuteReset  = 8'd194;
  localparam logic [ByteW-1:0] CaronReset  = 8'd207;
  localparam logic [ByteW-1:0] RingReset   = 8'd202;
  localparam logic [ByteW-1:0] UmlautReset = 8'd200;

  localparam logic [ByteW-1:0] DotCode    = 8'h2E;
  localparam logic [ByteW-1:0] BslashCode = 8'h5C;
  localparam logic [ByteW-1:0] DquoteCode = 8'h22;
  localparam logic [ByteW-1:0] LbraceCode = 8'h7B;
  localparam logic [ByteW-1:0] RbraceCode = 8'h7D;
  localparam logic [ByteW-1:0] LbrackCode = 8'h5B;
  localparam logic [ByteW-1:0] RbrackCode = 8'h5D;
  localparam logic [ByteW-1:0] FirstPrint = 8'h20;
  localparam logic [ByteW-1:0] LastPrint  = 8'h7E;

  // Mark byte codes as configured.
  typedef struct packed {
    logic [ByteW-1:0] acute;
    logic [ByteW-1:0] caron;
    logic [ByteW-1:0] ring;
    logic [ByteW-1:0] umlaut;
  } mark_cfg_t;

  // One result item.
  typedef struct packed {
    logic [CodeW-1:0] code_point;
    logic             last;
  } result_t;

  // All results of one text byte, in order, with their count.
  typedef struct packed {
    logic [1:0]               count;
    result_t [MaxRes-1:0]     res;
  } dec_t;

  // Letter table for the acute mark; unknown letters give a dot.
  function automatic logic [CodeW-1:0] map_acute(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] r;
    unique case (c)
      "A":     r = 9'h0C1;
      "E":     r = 9'h0C9;
      "I":     r = 9'h0CD;
      "O":     r = 9'h0D3;
      "U":     r = 9'h0DA;
      "Y":     r = 9'h0DD;
      "a":     r = 9'h0E1;
      "e":     r = 9'h0E9;
      "i":     r = 9'h0ED;
      "o":     r = 9'h0F3;
      "u":     r = 9'h0FA;
      "y":     r = 9'h0FD;
      default: r = {1'b0, DotCode};
    endcase
    return r;
  endfunction

  // Letter table for the caron; unknown letters give zero.
  function automatic logic [CodeW-1:0] map_caron(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] r;
    unique case (c)
      "C":     r = 9'h10C;
      "D":     r = 9'h10E;
      "E":     r = 9'h11A;
      "N":     r = 9'h147;
      "R":     r = 9'h158;
      "S":     r = 9'h160;
      "T":     r = 9'h164;
      "Z":     r = 9'h17D;
      "c":     r = 9'h10D;
      "d":     r = 9'h10F;
      "e":     r = 9'h11B;
      "n":     r = 9'h148;
      "r":     r = 9'h159;
      "s":     r = 9'h161;
      "t":     r = 9'h165;
      "z":     r = 9'h17E;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Letter table for the ring; only u and U are known.
  function automatic logic [CodeW-1:0] map_ring(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] r;
    unique case (c)
      "u":     r = 9'h16F;
      "U":     r = 9'h16E;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Letter table for the diaeresis; unknown letters give a dot.
  function automatic logic [CodeW-1:0] map_umlaut(input logic [ByteW-1:0] c);
    logic [CodeW-1:0] r;
    unique case (c)
      "A":     r = 9'h0C4;
      "E":     r = 9'h0CB;
      "O":     r = 9'h0D6;
      "U":     r = 9'h0DC;
      "a":     r = 9'h0E4;
      "e":     r = 9'h0EB;
      "o":     r = 9'h0F6;
      "u":     r = 9'h0FC;
      default: r = {1'b0, DotCode};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/i6dd_stream_if.sv -----
// Valid/ready channel interfaces for text bytes in and code points out.
// Depends on i6dd_pkg for the field widths.
`default_nettype none

interface i6dd_in_if
  import i6dd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface i6dd_out_if
  import i6dd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code_point;
  logic             last;

  modport source (output valid, output code_point, output last, input ready);
  modport sink   (input valid, input code_point, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/i6dd_cfg_regs.sv -----
// APB register file holding the four mark byte codes.
// Depends on i6dd_pkg for the register indexes and reset values.
`default_nettype none

module i6dd_cfg_regs
  import i6dd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output mark_cfg_t              cfg_o
);

  mark_cfg_t cfg_q;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.acute  <= AcuteReset;
      cfg_q.caron  <= CaronReset;
      cfg_q.ring   <= RingReset;
      cfg_q.umlaut <= UmlautReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_ACUTE:  cfg_q.acute  <= pwdata[ByteW-1:0];
        REG_CARON:  cfg_q.caron  <= pwdata[ByteW-1:0];
        REG_RING:   cfg_q.ring   <= pwdata[ByteW-1:0];
        REG_UMLAUT: cfg_q.umlaut <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ACUTE:  prdata[ByteW-1:0] = cfg_q.acute;
      REG_CARON:  prdata[ByteW-1:0] = cfg_q.caron;
      REG_RING:   prdata[ByteW-1:0] = cfg_q.ring;
      REG_UMLAUT: prdata[ByteW-1:0] = cfg_q.umlaut;
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/i6dd_decode.sv -----
// Combinational decode of one registered text byte into up to three results
// and the next pending mark. Depends on i6dd_pkg for tables and types.
`default_nettype none

module i6dd_decode
  import i6dd_pkg::*;
(
  input  wire logic [ByteW-1:0] text_byte_i,
  input  wire logic             end_of_text_i,
  input  mark_e                 pending_i,
  input  mark_cfg_t             cfg_i,
  output dec_t                  dec_o,
  output mark_e                 pending_o
);

  logic [1:0]       n_byte;
  result_t [MaxRes-1:0] res;
  logic             printable;
  mark_e            mark_nxt;

  assign printable = (text_byte_i >= FirstPrint) && (text_byte_i <= LastPrint)
                     && (text_byte_i != LbraceCode) && (text_byte_i != RbraceCode)
                     && (text_byte_i != LbrackCode) && (text_byte_i != RbrackCode);

  // Results caused by the byte itself, then the terminator if flagged.
  always_comb begin
    res      = '0;
    n_byte   = 2'd0;
    mark_nxt = MARK_NONE;
    if (pending_i != MARK_NONE) begin
      // Base letter of a pending mark.
      n_byte = 2'd1;
      unique case (pending_i)
        MARK_ACUTE: res[0].code_point = map_acute(text_byte_i);
        MARK_CARON: res[0].code_point = map_caron(text_byte_i);
        MARK_RING:  res[0].code_point = map_ring(text_byte_i);
        default:    res[0].code_point = map_umlaut(text_byte_i);
      endcase
    end else if (text_byte_i == cfg_i.acute) begin
      mark_nxt = MARK_ACUTE;
    end else if (text_byte_i == cfg_i.caron) begin
      mark_nxt = MARK_CARON;
    end else if (text_byte_i == cfg_i.ring) begin
      mark_nxt = MARK_RING;
    end else if (text_byte_i == cfg_i.umlaut) begin
      mark_nxt = MARK_UMLAUT;
    end else if (text_byte_i == DquoteCode || text_byte_i == BslashCode) begin
      // Escape with a leading backslash.
      n_byte            = 2'd2;
      res[0].code_point = {1'b0, BslashCode};
      res[1].code_point = {1'b0, text_byte_i};
    end else if (printable) begin
      n_byte            = 2'd1;
      res[0].code_point = {1'b0, text_byte_i};
    end else begin
      n_byte            = 2'd1;
      res[0].code_point = {1'b0, DotCode};
    end

    // End of text drops any pending mark and appends the terminator.
    if (end_of_text_i) begin
      mark_nxt            = MARK_NONE;
      res[n_byte]         = '0;
      res[n_byte].last    = 1'b1;
    end
  end

  assign dec_o.res   = res;
  assign dec_o.count = n_byte + {1'b0, end_of_text_i};
  assign pending_o   = mark_nxt;

endmodule

`default_nettype wire

// ----- sv/i6dd_out_queue.sv -----
// Result register: holds the up to three results of one byte and presents
// them one per cycle on the output channel while it is ready. Depends on i6dd_pkg.
`default_nettype none

module i6dd_out_queue
  import i6dd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  dec_t         dec_i,
  output logic         can_load_o,
  i6dd_out_if.source   code_o
);

  result_t [MaxRes-1:0] slot_q, slot_d;
  logic [1:0]           count_q, count_d;
  logic                 pop;

  assign pop        = code_o.valid && code_o.ready;
  // Loading is allowed when empty or once the last waiting result leaves this cycle.
  assign can_load_o = (count_q == 2'd0) || (count_q == 2'd1 && code_o.ready);

  assign code_o.valid      = (count_q != 2'd0);
  assign code_o.code_point = slot_q[0].code_point;
  assign code_o.last       = slot_q[0].last;

  // Next slot contents: fresh load, shift on a taken request, or hold.
  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    if (load_i) begin
      slot_d  = dec_i.res;
      count_d = dec_i.count;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      count_d   = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

// ----- sv/iso6937_diacritic_decoder_core.sv -----
// ISO 6937 diacritic decoder: text bytes in, Unicode code points out.
// A byte goes from the input register through the decode into the result register.
// Throughput: one byte per cycle while the output is ready; a byte with two or three
// results holds the input until all but its last result have left the output.
// Reset (rst_ni, async, low): channels empty, no mark pending, mark codes to defaults.
`default_nettype none

module iso6937_diacritic_decoder_core
  import i6dd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  i6dd_in_if.sink                text_i,
  i6dd_out_if.source             code_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  mark_cfg_t        cfg;
  logic             stage_v_q;
  logic [ByteW-1:0] byte_q;
  logic             eot_q;
  mark_e            pending_q, pending_d;
  dec_t             dec;
  logic             can_load;
  logic             move;
  logic             take;

  i6dd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register handshake: refill when empty or when the held byte moves on.
  assign move         = stage_v_q && can_load;
  assign text_i.ready = !stage_v_q || move;
  assign take         = text_i.valid && text_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      pending_q <= MARK_NONE;
    end else begin
      if (take) begin
        stage_v_q <= 1'b1;
      end else if (move) begin
        stage_v_q <= 1'b0;
      end
      if (move) begin
        pending_q <= pending_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= text_i.text_byte;
      eot_q  <= text_i.end_of_text;
    end
  end

  i6dd_decode u_dec (
    .text_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .pending_i     (pending_q),
    .cfg_i         (cfg),
    .dec_o         (dec),
    .pending_o     (pending_d)
  );

  i6dd_out_queue u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (move),
    .dec_i      (dec),
    .can_load_o (can_load),
    .code_o     (code_o)
  );

endmodule

`default_nettype wire
